// ----- rtl/core/umcp_pkg.sv -----
`default_nettype none

package umcp_pkg;

  // window and count limits
  localparam int unsigned BUFFER_DEPTH = 128;
  localparam int unsigned WINDOW_LEN   = 4;
  localparam int unsigned COUNT_W      = 8;

  // field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned MOTOR_W  = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MAG_W    = 8;
  localparam int unsigned PROD_W   = MAG_W + PERIOD_W;
  localparam int unsigned HEX_W    = 5;

  // packed stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  // reset value of the period register
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd200;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_M    = 8'h4D;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_TWO  = 8'h32;
  localparam logic [HEX_W-1:0]  HEX_BAD   = 5'd16;

  // signed speed split point
  localparam logic [CHAR_W-1:0] SPEED_MAX_FWD = 8'h7F;

  // reverse scaling is a divide by 128
  localparam int unsigned REV_SHIFT = 7;

  // divide by 127: floor(p/127) = ((p+1) * (2^21+2^14+2^7+1)) >> 28 for p < 2^23
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned DIV_W     = PROD_W + 22;

  // stage one holds a parsed command
  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic               rev;
    logic [PROD_W-1:0]  prod;
  } cmd_t;

  // hex digit value, HEX_BAD when not a hex digit
  function automatic logic [HEX_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [HEX_W-1:0] v;
    v = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = HEX_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = HEX_W'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = HEX_W'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/uart_motor_command_parser_core.sv -----
// UART motor command parser core.
// Input stream s_*: one received character per transfer; s_tuser carries the
// listening flag, and a character with listening low is taken and ignored.
// Characters are kept in a four-entry window with a count that saturates at
// BUFFER_DEPTH. A carriage return with at least four stored characters closes
// a command 'M', motor '1'/'2', two hex digits (a signed speed). A good command
// makes one result on m_* (motor, direction, duty scaled to pwm_period) and
// clears the count; a bad one is dropped.
// Config channel cfg_*: writes pwm_period, always ready; write it only while
// no command is in flight.
// A result passes the parsed-command stage (parse and 8x16 multiply) and then
// the result register (constant divide) after the closing carriage return is
// taken. Throughput: one character per cycle; s_tready stays high unless
// both stages hold a result while m_tready is low.
// Reset: window and count clear, pwm_period returns to 200, no result pending.
// A stall on m_tready holds the result; new characters are still taken until
// the parsed-command stage is also full.

`default_nettype none

module uart_motor_command_parser_core
  import umcp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
  input  wire logic                   s_tuser,   // [0] listening
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_DATA_W-1:0]  m_tdata,   // [1:0] motor_select, [2] reverse,
                                                 // [18:3] duty, [23:19] zero
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [PERIOD_W-1:0]    cfg_data
);

  logic [CHAR_W-1:0]   recent [WINDOW_LEN];
  logic [COUNT_W-1:0]  count;
  logic [PERIOD_W-1:0] pwm_period;

  logic                a_valid;
  cmd_t                a_cmd;
  logic [MOTOR_W-1:0]  out_motor;
  logic                out_rev;
  logic [PERIOD_W-1:0] out_duty;

  logic                accept;
  logic                adv_out;
  logic                rx_listen;
  logic [CHAR_W-1:0]   rx_char;
  logic                closing;
  logic                good;
  logic                store;
  logic [HEX_W-1:0]    hi_val;
  logic [HEX_W-1:0]    lo_val;
  logic [CHAR_W-1:0]   speed;
  logic [MAG_W-1:0]    mag;
  logic                rev;
  cmd_t                cmd_next;
  logic [PROD_W-1:0]   prod_inc;
  logic [DIV_W-1:0]    div_sum;
  logic [PERIOD_W-1:0] duty_next;

  // handshakes
  assign cfg_ready = 1'b1;
  assign adv_out   = !m_tvalid || m_tready;
  assign s_tready  = !a_valid || adv_out;
  assign accept    = s_tvalid && s_tready;
  assign rx_char   = s_tdata[CHAR_W-1:0];
  assign rx_listen = s_tuser;

  // command check on the stored window
  always_comb begin
    hi_val  = hex_value(recent[2]);
    lo_val  = hex_value(recent[3]);
    speed   = {hi_val[3:0], lo_val[3:0]};
    closing = rx_listen && (rx_char == CHAR_CR) && (count >= COUNT_W'(WINDOW_LEN));
    good    = closing && (recent[0] == CHAR_M) &&
              ((recent[1] == CHAR_ONE) || (recent[1] == CHAR_TWO)) &&
              (hi_val != HEX_BAD) && (lo_val != HEX_BAD);
    store   = rx_listen && !closing && (count < COUNT_W'(BUFFER_DEPTH));
    rev     = speed > SPEED_MAX_FWD;
    mag     = rev ? MAG_W'(9'h100 - {1'b0, speed}) : speed;
    cmd_next.motor = recent[1][MOTOR_W-1:0];
    cmd_next.rev   = rev;
    cmd_next.prod  = PROD_W'(mag) * PROD_W'(pwm_period);
  end

  // window and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        recent[i] <= '0;
      end
    end else if (accept) begin
      if (good) begin
        count <= '0;
      end else if (store) begin
        count <= count + 1'b1;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          recent[i] <= recent[i+1];
        end
        recent[WINDOW_LEN-1] <= rx_char;
      end
    end
  end

  // period register
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pwm_period <= cfg_data;
    end
  end

  // parsed command stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= accept && good;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && accept && good) begin
      a_cmd <= cmd_next;
    end
  end

  // duty scaling: shift for reverse, reciprocal shift-add for forward
  always_comb begin
    prod_inc = a_cmd.prod + 1'b1;
    div_sum  = (DIV_W'(prod_inc) << 21) + (DIV_W'(prod_inc) << 14) +
               (DIV_W'(prod_inc) << 7) + DIV_W'(prod_inc);
    if (a_cmd.rev) begin
      duty_next = PERIOD_W'(a_cmd.prod >> REV_SHIFT);
    end else begin
      duty_next = div_sum[DIV_SHIFT +: PERIOD_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && a_valid) begin
      out_motor <= a_cmd.motor;
      out_rev   <= a_cmd.rev;
      out_duty  <= duty_next;
    end
  end

  assign m_tdata = {(OUT_DATA_W - MOTOR_W - 1 - PERIOD_W)'(0), out_duty, out_rev, out_motor};

  // count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(BUFFER_DEPTH))
    else $error("stored count above buffer depth");

  // a taken good command clears the count
  a_good_clears: assert property (@(posedge clk) disable iff (rst)
    accept && good |=> count == '0)
    else $error("count not cleared after good command");

  // ignored characters leave the count alone
  a_idle_char: assert property (@(posedge clk) disable iff (rst)
    accept && !rx_listen |=> $stable(count))
    else $error("count moved on ignored character");

  // a parsed command waits while the result register is held
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv_out |=> a_valid && $stable(a_cmd))
    else $error("parsed command lost under stall");

  // results only address motor one or two
  a_motor_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_motor == 2'd1) || (out_motor == 2'd2))
    else $error("bad motor code in result");

endmodule

`default_nettype wire
